// ===== src/lre_pkg.sv =====
// ----------------------------------------------------------------------------
// lre_pkg
// Types and constants shared by the left-to-right expression evaluator.
// ----------------------------------------------------------------------------
package lre_pkg;

   // datapath width of numbers and results
   localparam int VALUE_W = 32;

   // ascii codes that the front end recognizes
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // decimal base for building numbers
   localparam logic [VALUE_W-1:0] DECIMAL_BASE = 32'd10;

   // error codes reported with each result
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
   localparam logic [1:0] ERR_DIV_ZERO = 2'd2;

   // arithmetic operators
   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // class of one character
   typedef enum logic [1:0] {
      CMD_DIGIT = 2'd0,
      CMD_OP    = 2'd1,
      CMD_BAD   = 2'd2
   } cmd_kind_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_CLOSE = 2'd1,
      ST_DIV   = 2'd2,
      ST_EMIT  = 2'd3
   } state_type;

   // request payload
   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } req_type;

   // result payload
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [1:0]                error_code;
   } rsp_type;

   // classified character handed from front to back
   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   digit;
      op_type       op;
      logic         last;
   } cmd_type;

   // divider start bundle
   typedef struct packed {
      logic               start;
      logic [VALUE_W-1:0] dividend;
      logic [VALUE_W-1:0] divisor;
   } div_req_type;

   // divider completion bundle
   typedef struct packed {
      logic               done;
      logic [VALUE_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== src/lre_front.sv =====
// ----------------------------------------------------------------------------
// lre_front
// Accepts request characters and classifies them into digit, operator or
// invalid commands for the back end queue.
// ----------------------------------------------------------------------------
module lre_front import lre_pkg::*; (
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    push_valid,
   input  logic    push_ready,
   output cmd_type push_cmd
);

   logic [7:0] char_diff;

   // request flows straight into the queue
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign char_diff  = req_payload.char_code - CHAR_ZERO;

   // character classification
   always_comb begin
      push_cmd.last  = req_payload.last;
      push_cmd.digit = char_diff[3:0];
      push_cmd.op    = OP_ADD;
      push_cmd.kind  = CMD_BAD;
      if ((req_payload.char_code >= CHAR_ZERO) && (req_payload.char_code <= CHAR_NINE)) begin
         push_cmd.kind = CMD_DIGIT;
      end else if (req_payload.char_code == CHAR_PLUS) begin
         push_cmd.kind = CMD_OP;
         push_cmd.op   = OP_ADD;
      end else if (req_payload.char_code == CHAR_MINUS) begin
         push_cmd.kind = CMD_OP;
         push_cmd.op   = OP_SUB;
      end else if (req_payload.char_code == CHAR_STAR) begin
         push_cmd.kind = CMD_OP;
         push_cmd.op   = OP_MUL;
      end else if (req_payload.char_code == CHAR_SLASH) begin
         push_cmd.kind = CMD_OP;
         push_cmd.op   = OP_DIV;
      end
   end

endmodule

// ===== src/lre_queue.sv =====
// ----------------------------------------------------------------------------
// lre_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lre_queue import lre_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/lre_divider.sv =====
// ----------------------------------------------------------------------------
// lre_divider
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero.
// ----------------------------------------------------------------------------
module lre_divider import lre_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int STEP_W = $clog2(VALUE_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [VALUE_W-1:0]  rem_ff, rem_in;
   logic [VALUE_W-1:0]  quo_ff, quo_in;
   logic [VALUE_W-1:0]  mag_b_ff, mag_b_in;
   logic                neg_ff, neg_in;
   logic [VALUE_W:0]    trial;
   logic [VALUE_W:0]    trial_diff;
   logic                fits;

   // one restoring step
   assign trial      = {rem_ff, quo_ff[VALUE_W-1]};
   assign trial_diff = trial - {1'b0, mag_b_ff};
   assign fits       = (trial >= {1'b0, mag_b_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      mag_b_in = mag_b_ff;
      neg_in   = neg_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         rem_in   = '0;
         quo_in   = div_req.dividend[VALUE_W-1] ? ('0 - div_req.dividend) : div_req.dividend;
         mag_b_in = div_req.divisor[VALUE_W-1] ? ('0 - div_req.divisor) : div_req.divisor;
         neg_in   = div_req.dividend[VALUE_W-1] ^ div_req.divisor[VALUE_W-1];
      end else if (busy_ff) begin
         rem_in  = fits ? trial_diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
         quo_in  = {quo_ff[VALUE_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(VALUE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      mag_b_ff <= mag_b_in;
      neg_ff   <= neg_in;
   end

   // sign fix on the finished quotient
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? ('0 - quo_ff) : quo_ff;

endmodule

// ===== src/lre_back.sv =====
// ----------------------------------------------------------------------------
// lre_back
// Executes classified commands: builds numbers, combines them left to right
// and drives the result register.
// ----------------------------------------------------------------------------
module lre_back import lre_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    pop_valid,
   output logic    pop_ready,
   input  cmd_type pop_cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   state_type           state_ff, state_in;
   logic [VALUE_W-1:0]  acc_ff, acc_in;
   logic [VALUE_W-1:0]  cur_ff, cur_in;
   logic [VALUE_W-1:0]  num_ff, num_in;
   op_type              op_ff, op_in;
   logic                have_ff, have_in;
   logic [1:0]          err_ff, err_in;
   logic                first_ff, first_in;
   cmd_type             cmd_ff, cmd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic [VALUE_W-1:0]  cur_next;
   logic [VALUE_W-1:0]  product;
   logic                close_fin;
   logic                div_zero;
   logic                need_div;
   logic                out_free;
   logic                trail_close;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   lre_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // number building and multiply
   assign cur_next = (cur_ff * DECIMAL_BASE) + {{(VALUE_W-4){1'b0}}, pop_cmd.digit};
   assign product  = acc_ff * num_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // close decode
   always_comb begin
      close_fin = 1'b0;
      div_zero  = 1'b0;
      need_div  = 1'b0;
      unique case (state_ff)
         ST_CLOSE: begin
            if (!have_ff || (op_ff != OP_DIV)) begin
               close_fin = 1'b1;
            end else if (num_ff == '0) begin
               close_fin = 1'b1;
               div_zero  = 1'b1;
            end else begin
               need_div = 1'b1;
            end
         end
         ST_DIV:  close_fin = div_rsp.done;
         default: close_fin = 1'b0;
      endcase
   end

   // a non-digit last character closes a trailing empty number
   assign trail_close = first_ff && cmd_ff.last && (cmd_ff.kind != CMD_DIGIT);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid && ((pop_cmd.kind != CMD_DIGIT) || pop_cmd.last)) begin
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE, ST_DIV: begin
            priority if (need_div) begin
               state_in = ST_DIV;
            end else if (close_fin && trail_close) begin
               state_in = ST_CLOSE;
            end else if (close_fin && cmd_ff.last) begin
               state_in = ST_EMIT;
            end else if (close_fin) begin
               state_in = ST_IDLE;
            end else begin
               state_in = state_ff;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      logic [1:0] err_v;
      err_v        = err_ff;
      acc_in       = acc_ff;
      cur_in       = cur_ff;
      num_in       = num_ff;
      op_in        = op_ff;
      have_in      = have_ff;
      first_in     = first_ff;
      cmd_in       = cmd_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop_ready    = 1'b0;
      div_req.start    = need_div;
      div_req.dividend = acc_ff;
      div_req.divisor  = num_ff;

      unique case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cmd_in   = pop_cmd;
               first_in = 1'b1;
               if (pop_cmd.kind == CMD_DIGIT) begin
                  cur_in = cur_next;
                  num_in = cur_next;
               end else begin
                  num_in = cur_ff;
                  cur_in = '0;
               end
            end
         end
         ST_CLOSE, ST_DIV: begin
            // combine closed number into accumulator
            if (state_ff == ST_DIV) begin
               if (div_rsp.done) begin
                  acc_in = div_rsp.quotient;
               end
            end else if (!have_ff) begin
               acc_in  = num_ff;
               have_in = 1'b1;
            end else begin
               unique case (op_ff)
                  OP_ADD:  acc_in = acc_ff + num_ff;
                  OP_SUB:  acc_in = acc_ff - num_ff;
                  OP_MUL:  acc_in = product;
                  default: acc_in = acc_ff;
               endcase
            end
            if (div_zero && (err_v == ERR_NONE)) begin
               err_v = ERR_DIV_ZERO;
            end
            // operator or invalid character takes effect after its close
            if (close_fin && first_ff) begin
               unique case (cmd_ff.kind)
                  CMD_OP: op_in = cmd_ff.op;
                  CMD_BAD: begin
                     if (err_v == ERR_NONE) begin
                        err_v = ERR_BAD_CHAR;
                     end
                  end
                  default: op_in = op_ff;
               endcase
               first_in = 1'b0;
               if (trail_close) begin
                  num_in = '0;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_in.value      = acc_ff;
               rsp_in.error_code = err_ff;
               rsp_valid_in      = 1'b1;
               acc_in            = '0;
               cur_in            = '0;
               op_in             = OP_ADD;
               have_in           = 1'b0;
               err_v             = ERR_NONE;
            end
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
      err_in = err_v;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         cur_ff       <= '0;
         op_ff        <= OP_ADD;
         have_ff      <= 1'b0;
         err_ff       <= ERR_NONE;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         cur_ff       <= cur_in;
         op_ff        <= op_in;
         have_ff      <= have_in;
         err_ff       <= err_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // divider starts only from a close with a nonzero divisor
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (state_ff == ST_CLOSE) && have_ff && (num_ff != '0))
      else $error("divider started outside a division close");

   // commands leave the queue only while idle
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |-> (state_ff == ST_IDLE))
      else $error("command popped while busy");

   // a recorded error holds until the result is built
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      ((err_ff != ERR_NONE) && (state_ff != ST_EMIT)) |=> (err_ff == $past(err_ff)))
      else $error("sticky error changed before result");

   // a division in progress always has an accumulator to divide
   a_div_have: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> have_ff)
      else $error("division without accumulator");

endmodule

// ===== src/left_to_right_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// left_to_right_expression_evaluator
// Immediate-execution calculator over a stream of ascii characters.
// ----------------------------------------------------------------------------
// One request carries one character. Digits build the current number; any
// other character closes it and applies the pending operator strictly left to
// right, with signed truncating division. The request marked last produces one
// result with a 32-bit wrapped value and an error code (1 invalid character,
// 2 division by zero; the first error is kept), then the state clears. A front
// end classifies requests into a queue of QUEUE_DEPTH entries, so requests are
// taken while the back end works. In the back end a digit is absorbed while
// idle; an operator or invalid character also passes through a close, and a
// close that divides waits for the one-bit-per-cycle divider. A last digit adds
// its close and an emit; a non-digit last character adds an emit and one more
// close, which never divides. The emit waits while an earlier result is still
// held in the result register.
module left_to_right_expression_evaluator import lre_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   // request classification
   lre_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_cmd    (push_cmd)
   );

   // decoupling queue
   lre_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // execution and result register
   lre_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_cmd     (pop_cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
